// ----- rtl/core/yz0_pkg.sv -----
// Shared types and constants of the Yaz0 stream decoder.
package yz0_pkg;

   localparam int WINDOW_DEPTH = 4096;
   localparam int PTR_W        = 12;
   localparam int MAX_LANES    = 8;
   localparam int HDR_LEN      = 16;
   localparam int LEN_W        = 9;

   localparam logic [7:0] MAGIC [4] = '{8'h59, 8'h61, 8'h7A, 8'h30};
   localparam logic [7:0] LIT_BIT   = 8'h80;
   localparam logic [7:0] DIST_HI   = 8'h0F;
   localparam logic [8:0] SHORT_ADD = 9'd2;
   localparam logic [8:0] LONG_ADD  = 9'h12;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_CODE,
      PH_TOKEN,
      PH_MATCH2,
      PH_MATCH3
   } phase_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CP_RD,
      ST_CP_WR
   } state_type;

endpackage

// ----- rtl/core/yz0_req_if.sv -----
// Compressed byte channel.
interface yz0_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       first;

   modport source (output valid, in_byte, first, input ready);
   modport sink   (input valid, in_byte, first, output ready);
endinterface

// ----- rtl/core/yz0_rsp_if.sv -----
// Decompressed byte group channel.
interface yz0_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte0;
   logic [7:0] byte1;
   logic [7:0] byte2;
   logic [7:0] byte3;
   logic [7:0] byte4;
   logic [7:0] byte5;
   logic [7:0] byte6;
   logic [7:0] byte7;
   logic [3:0] count;
   logic       last;
   logic       error;

   modport source (output valid, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
                   byte7, count, last, error, input ready);
   modport sink   (input valid, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
                   byte7, count, last, error, output ready);
endinterface

// ----- rtl/core/yz0_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module yz0_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/core/yaz0_stream_decoder_top.sv -----
// Top level of the Yaz0 stream decoder.
//
// req_ch carries one compressed byte per beat; first marks header byte 0 of
// a stream and always restarts header parsing. rsp_ch carries groups of up
// to LANES decompressed bytes with count, last and error.
// After reset the 4096-byte history is cleared, one entry per cycle, so the
// block takes no beat until the clear is done.
// A literal's group is registered in the cycle after acceptance, and a new
// beat is taken once the output register is empty. A back-reference copies
// each byte by a read of the history RAM, then a write back; groups leave as
// they fill. A stalled receiver holds the output register and the copy
// waits at the next group that is ready to leave. A bad magic gives one
// result with error set; a zero stated size gives one empty result with
// last set.
module yaz0_stream_decoder_top #(
   parameter int LANES = 8
) (
   input  logic     clock,
   input  logic     reset,
   yz0_req_if.sink  req_ch,
   yz0_rsp_if.source rsp_ch
);
   localparam int PW = yz0_pkg::PTR_W;
   localparam int LW = yz0_pkg::LEN_W;

   yz0_pkg::state_type state_ff, state_in;
   yz0_pkg::phase_type phase_ff, phase_in;

   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] src_ff, src_in;
   logic [PW-1:0] clr_ff, clr_in;
   logic [PW-1:0] dist_ff, dist_in;
   logic [31:0]   rem_ff, rem_in;
   logic [4:0]    hidx_ff, hidx_in;
   logic [7:0]    code_ff, code_in;
   logic [3:0]    bits_ff, bits_in;
   logic [7:0]    held_ff, held_in;
   logic          magic_ff, magic_in;
   logic          halted_ff, halted_in;
   logic [LW-1:0] len_ff, len_in;
   logic          fin_ff, fin_in;

   logic [7:0]    acc_ff [yz0_pkg::MAX_LANES];
   logic [7:0]    acc_in [yz0_pkg::MAX_LANES];
   logic [3:0]    acc_cnt_ff, acc_cnt_in;

   logic          ov_ff, ov_in;
   logic [7:0]    lane_ff [yz0_pkg::MAX_LANES];
   logic [7:0]    lane_in [yz0_pkg::MAX_LANES];
   logic [3:0]    ocnt_ff, ocnt_in;
   logic          olast_ff, olast_in;
   logic          oerr_ff, oerr_in;

   logic          we;
   logic [PW-1:0] waddr;
   logic [7:0]    wdata;
   logic [7:0]    rdata;

   yz0_ram #(.WIDTH(8), .DEPTH(yz0_pkg::WINDOW_DEPTH)) u_hist (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (src_ff),
      .rdata (rdata)
   );

   logic accept;
   logic out_free;

   assign req_ch.ready = (state_ff == yz0_pkg::ST_IDLE) && !ov_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !ov_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= yz0_pkg::ST_CLEAR;
         phase_ff  <= yz0_pkg::PH_HEADER;
         wp_ff     <= '0;
         clr_ff    <= '0;
         rem_ff    <= '0;
         hidx_ff   <= '0;
         code_ff   <= '0;
         bits_ff   <= '0;
         held_ff   <= '0;
         dist_ff   <= '0;
         magic_ff  <= 1'b1;
         halted_ff <= 1'b1;
         acc_cnt_ff <= '0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         wp_ff     <= wp_in;
         clr_ff    <= clr_in;
         rem_ff    <= rem_in;
         hidx_ff   <= hidx_in;
         code_ff   <= code_in;
         bits_ff   <= bits_in;
         held_ff   <= held_in;
         dist_ff   <= dist_in;
         magic_ff  <= magic_in;
         halted_ff <= halted_in;
         acc_cnt_ff <= acc_cnt_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff   <= src_in;
      len_ff   <= len_in;
      fin_ff   <= fin_in;
      acc_ff   <= acc_in;
      lane_ff  <= lane_in;
      ocnt_ff  <= ocnt_in;
      olast_ff <= olast_in;
      oerr_ff  <= oerr_in;
   end

   always_comb begin
      logic [7:0]    b;
      logic [8:0]    run;
      logic          do_copy;
      logic [3:0]    nc;
      logic          push;

      b        = req_ch.in_byte;
      run      = '0;
      do_copy  = 1'b0;
      nc       = '0;
      push     = 1'b0;

      state_in  = state_ff;
      phase_in  = phase_ff;
      wp_in     = wp_ff;
      src_in    = src_ff;
      clr_in    = clr_ff;
      dist_in   = dist_ff;
      rem_in    = rem_ff;
      hidx_in   = hidx_ff;
      code_in   = code_ff;
      bits_in   = bits_ff;
      held_in   = held_ff;
      magic_in  = magic_ff;
      halted_in = halted_ff;
      len_in    = len_ff;
      fin_in    = fin_ff;
      acc_in    = acc_ff;
      acc_cnt_in = acc_cnt_ff;
      ov_in     = ov_ff && !rsp_ch.ready;
      lane_in   = lane_ff;
      ocnt_in   = ocnt_ff;
      olast_in  = olast_ff;
      oerr_in   = oerr_ff;
      we        = 1'b0;
      waddr     = wp_ff;
      wdata     = b;

      unique case (state_ff)
         yz0_pkg::ST_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            wdata  = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == PW'(yz0_pkg::WINDOW_DEPTH - 1)) begin
               state_in = yz0_pkg::ST_IDLE;
            end
         end
         yz0_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_ch.first) begin
                  halted_in = 1'b0;
                  phase_in  = yz0_pkg::PH_HEADER;
                  hidx_in   = '0;
                  magic_in  = 1'b1;
                  rem_in    = '0;
                  bits_in   = '0;
                  code_in   = '0;
               end
               if (!halted_in) begin
                  unique case (phase_in)
                     yz0_pkg::PH_HEADER: begin
                        if (hidx_in < 5'd4) begin
                           if (b != yz0_pkg::MAGIC[hidx_in[1:0]]) begin
                              magic_in = 1'b0;
                           end
                        end else if (hidx_in < 5'd8) begin
                           rem_in = {rem_in[23:0], b};
                        end
                        hidx_in = hidx_in + 1'b1;
                        if (hidx_in >= 5'(yz0_pkg::HDR_LEN)) begin
                           hidx_in  = 5'(yz0_pkg::HDR_LEN);
                           phase_in = yz0_pkg::PH_CODE;
                           bits_in  = '0;
                           if (!magic_in || rem_in == '0) begin
                              halted_in = 1'b1;
                              ov_in     = 1'b1;
                              for (int j = 0; j < yz0_pkg::MAX_LANES; j++) begin
                                 lane_in[j] = '0;
                              end
                              ocnt_in  = '0;
                              oerr_in  = !magic_in;
                              olast_in = magic_in;
                           end
                        end
                     end
                     yz0_pkg::PH_CODE: begin
                        code_in  = b;
                        bits_in  = 4'd8;
                        phase_in = yz0_pkg::PH_TOKEN;
                     end
                     yz0_pkg::PH_TOKEN: begin
                        if ((code_in & yz0_pkg::LIT_BIT) != '0) begin
                           we     = 1'b1;
                           waddr  = wp_ff;
                           wp_in  = wp_ff + 1'b1;
                           rem_in = rem_in - 32'd1;
                           ov_in  = 1'b1;
                           for (int j = 0; j < yz0_pkg::MAX_LANES; j++) begin
                              lane_in[j] = (j == 0) ? b : 8'h00;
                           end
                           ocnt_in  = 4'd1;
                           olast_in = (rem_in == '0);
                           oerr_in  = 1'b0;
                           code_in  = {code_in[6:0], 1'b0};
                           if (bits_in != '0) bits_in = bits_in - 1'b1;
                           phase_in = (bits_in == '0) ? yz0_pkg::PH_CODE
                                                      : yz0_pkg::PH_TOKEN;
                           if (rem_in == '0) halted_in = 1'b1;
                        end else begin
                           held_in  = b;
                           phase_in = yz0_pkg::PH_MATCH2;
                        end
                     end
                     yz0_pkg::PH_MATCH2: begin
                        dist_in = {held_ff[3:0] & yz0_pkg::DIST_HI[3:0], b};
                        if (held_ff[7:4] != '0) begin
                           do_copy = 1'b1;
                           run     = {5'd0, held_ff[7:4]} + yz0_pkg::SHORT_ADD;
                        end else begin
                           phase_in = yz0_pkg::PH_MATCH3;
                        end
                     end
                     yz0_pkg::PH_MATCH3: begin
                        do_copy = 1'b1;
                        run     = {1'b0, b} + yz0_pkg::LONG_ADD;
                     end
                     default: halted_in = 1'b1;
                  endcase
                  if (do_copy) begin
                     len_in = (rem_in < {23'd0, run}) ? rem_in[LW-1:0] : run;
                     rem_in = rem_in - {23'd0, len_in};
                     fin_in = (rem_in == '0);
                     src_in = wp_ff - dist_in - 1'b1;
                     code_in = {code_in[6:0], 1'b0};
                     if (bits_in != '0) bits_in = bits_in - 1'b1;
                     phase_in = (bits_in == '0) ? yz0_pkg::PH_CODE
                                                : yz0_pkg::PH_TOKEN;
                     if (rem_in == '0) halted_in = 1'b1;
                     if (len_in != '0) begin
                        state_in   = yz0_pkg::ST_CP_RD;
                        acc_cnt_in = '0;
                     end
                  end
               end
            end
         end
         yz0_pkg::ST_CP_RD: begin
            state_in = yz0_pkg::ST_CP_WR;
         end
         yz0_pkg::ST_CP_WR: begin
            nc   = acc_cnt_ff + 1'b1;
            push = (nc == 4'(LANES)) || (len_ff == LW'(1));
            if (!push || out_free) begin
               we     = 1'b1;
               waddr  = wp_ff;
               wdata  = rdata;
               wp_in  = wp_ff + 1'b1;
               src_in = src_ff + 1'b1;
               len_in = len_ff - 1'b1;
               acc_in[acc_cnt_ff[2:0]] = rdata;
               acc_cnt_in = nc;
               if (push) begin
                  ov_in = 1'b1;
                  for (int j = 0; j < yz0_pkg::MAX_LANES; j++) begin
                     if (j < int'(nc)) begin
                        lane_in[j] = (j == int'(acc_cnt_ff)) ? rdata : acc_ff[j];
                     end else begin
                        lane_in[j] = '0;
                     end
                  end
                  ocnt_in    = nc;
                  olast_in   = fin_ff && (len_ff == LW'(1));
                  oerr_in    = 1'b0;
                  acc_cnt_in = '0;
               end
               state_in = (len_ff == LW'(1)) ? yz0_pkg::ST_IDLE : yz0_pkg::ST_CP_RD;
            end
         end
         default: state_in = yz0_pkg::ST_IDLE;
      endcase
   end

   assign rsp_ch.valid = ov_ff;
   assign rsp_ch.byte0 = lane_ff[0];
   assign rsp_ch.byte1 = lane_ff[1];
   assign rsp_ch.byte2 = lane_ff[2];
   assign rsp_ch.byte3 = lane_ff[3];
   assign rsp_ch.byte4 = lane_ff[4];
   assign rsp_ch.byte5 = lane_ff[5];
   assign rsp_ch.byte6 = lane_ff[6];
   assign rsp_ch.byte7 = lane_ff[7];
   assign rsp_ch.count = ocnt_ff;
   assign rsp_ch.last  = olast_ff;
   assign rsp_ch.error = oerr_ff;
endmodule
